// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CET_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define CET_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/cet_pkg.sv -----
// types and constants of the color escape transcoder
`default_nettype none

package cet_pkg;

   localparam int unsigned MAX_EMIT            = 5;
   localparam int unsigned EMIT_IDX_W          = $clog2(MAX_EMIT);
   localparam int unsigned EMIT_CNT_W          = $clog2(MAX_EMIT + 1);
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SOH   = 8'h01;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_D0    = 8'h30;
   localparam logic [7:0] CH_D1    = 8'h31;
   localparam logic [7:0] CH_D3    = 8'h33;
   localparam logic [7:0] CH_D4    = 8'h34;
   localparam logic [7:0] CH_D5    = 8'h35;
   localparam logic [7:0] CH_D7    = 8'h37;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_EF    = 8'hEF;
   localparam logic [7:0] CH_94    = 8'h94;
   localparam logic [7:0] CH_98    = 8'h98;
   localparam logic [7:0] CH_9C    = 8'h9C;
   localparam logic [7:0] CH_80    = 8'h80;
   localparam logic [7:0] CH_87    = 8'h87;

   typedef struct packed {
      logic       action;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       value_end;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [MAX_EMIT-1:0][7:0] chars;
      logic [EMIT_CNT_W-1:0]    count;
   } emit_list_type;

   typedef struct packed {
      emit_list_type text;
      logic          value_end;
   } desc_type;

   typedef enum logic [5:0] {
      PH_START = 6'b000001,
      PH_AFTERQ = 6'b000010,
      PH_SKIP1 = 6'b000100,
      PH_SKIP2 = 6'b001000,
      PH_BODY = 6'b010000,
      PH_DONE = 6'b100000
   } phase_type;

   typedef enum logic [3:0] {
      KIND_NONE = 4'b0001,
      KIND_BSL = 4'b0010,
      KIND_EF = 4'b0100,
      KIND_ESC = 4'b1000
   } kind_type;

endpackage

`default_nettype wire

// ----- src/cet_queue.sv -----
// descriptor queue between the front and back parts
`default_nettype none

module cet_queue
   import cet_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output      logic     push_ready,
   input  wire desc_type push_desc,
   output      logic     pop_valid,
   input  wire logic     pop_ready,
   output      desc_type pop_desc
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   desc_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_desc   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// ----- src/cet_front.sv -----
// front part: parses each input byte and builds its output text descriptor
`default_nettype none

module cet_front
   import cet_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output      logic     req_ready,
   input  wire req_type  req_payload,
   output      logic     push_valid,
   input  wire logic     push_ready,
   output      desc_type push_desc
);

   function automatic emit_list_type append(emit_list_type l, logic [7:0] c);
      emit_list_type r;
      r = l;
      if (r.count < EMIT_CNT_W'(MAX_EMIT)) begin
         r.chars[r.count[EMIT_IDX_W-1:0]] = c;
         r.count = r.count + 1'b1;
      end
      return r;
   endfunction

   function automatic emit_list_type put_char(emit_list_type l, logic [7:0] c);
      emit_list_type r;
      r = l;
      if (c == CH_TAB) begin
         r = append(r, CH_PCT);
         r = append(r, CH_T);
      end else if (c == CH_LF) begin
         r = append(r, CH_PCT);
         r = append(r, CH_R);
      end else if (c != CH_CR) begin
         r = append(r, c);
      end
      return r;
   endfunction

   function automatic emit_list_type put_color(emit_list_type l, logic [7:0] letter);
      emit_list_type r;
      r = append(l, CH_PCT);
      r = append(r, CH_X);
      r = append(r, letter);
      return r;
   endfunction

   function automatic logic [7:0] fg_letter(logic [2:0] d);
      logic [7:0] r;
      case (d)
         3'd0: r = "x";
         3'd1: r = "r";
         3'd2: r = "g";
         3'd3: r = "y";
         3'd4: r = "b";
         3'd5: r = "m";
         3'd6: r = "c";
         default: r = "w";
      endcase
      return r;
   endfunction

   function automatic logic [7:0] bg_letter(logic [2:0] d);
      logic [7:0] r;
      case (d)
         3'd0: r = "X";
         3'd1: r = "R";
         3'd2: r = "G";
         3'd3: r = "Y";
         3'd4: r = "B";
         3'd5: r = "M";
         3'd6: r = "C";
         default: r = "W";
      endcase
      return r;
   endfunction

   function automatic logic [7:0] attr_code(logic [2:0] d);
      logic [7:0] r;
      case (d)
         3'd0: r = "n";
         3'd1: r = "h";
         3'd4: r = "u";
         3'd5: r = "f";
         3'd7: r = "i";
         default: r = CH_NUL;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] attr_letter(logic [7:0] d);
      logic [7:0] r;
      r = CH_NUL;
      if (d >= CH_D0 && d <= CH_D7) begin
         r = attr_code(d[2:0]);
      end
      return r;
   endfunction

   function automatic logic [7:0] ef_letter(logic [7:0] mid, logic [7:0] lo);
      logic [7:0] r;
      r = CH_NUL;
      if (lo >= CH_80 && lo <= CH_87) begin
         if (mid == CH_98) begin
            r = fg_letter(lo[2:0]);
         end else if (mid == CH_9C) begin
            r = bg_letter(lo[2:0]);
         end else begin
            r = attr_code(lo[2:0]);
         end
      end
      return r;
   endfunction

   phase_type       phase_ff, phase_in;
   kind_type        kind_ff, kind_in;
   logic [1:0]      count_ff, count_in;
   logic [2:0][7:0] held_ff, held_in;
   emit_list_type   lst;
   logic            accept;

   always_comb begin
      logic       run_body;
      logic       replay_cur;
      logic       esc_fail;
      logic [7:0] b;
      logic [7:0] c;
      logic [7:0] l;
      b          = req_payload.in_byte;
      c          = b;
      l          = ef_letter(held_ff[0], b);
      lst        = '0;
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      count_in   = count_ff;
      held_in    = held_ff;
      run_body   = 1'b0;
      replay_cur = 1'b0;
      esc_fail   = 1'b1;

      if (req_payload.action) begin
         if (phase_ff == PH_BODY) begin
            case (kind_ff)
               KIND_BSL: lst = append(lst, CH_BSL);
               KIND_EF: begin
                  lst = append(lst, CH_EF);
                  if (count_ff != 2'd0) begin
                     lst = append(lst, held_ff[0]);
                  end
               end
               KIND_ESC: begin
                  for (int i = 0; i < 3; i++) begin
                     if (2'(i) < count_ff) begin
                        lst = append(lst, held_ff[i]);
                     end
                  end
               end
               default: ;
            endcase
         end
         kind_in  = KIND_NONE;
         count_in = 2'd0;
         phase_in = PH_START;
      end else begin
         case (phase_ff)
            PH_START: begin
               if (b == CH_QUOTE) begin
                  phase_in = PH_AFTERQ;
               end else if (b == CH_SOH) begin
                  phase_in = PH_SKIP1;
               end else begin
                  phase_in = PH_BODY;
                  run_body = 1'b1;
               end
            end
            PH_AFTERQ: begin
               if (b == CH_SOH) begin
                  phase_in = PH_SKIP1;
               end else begin
                  phase_in = PH_BODY;
                  run_body = 1'b1;
               end
            end
            PH_SKIP1: begin
               if (b == CH_COLON) begin
                  phase_in = PH_SKIP2;
               end else if (b == CH_NUL) begin
                  phase_in = PH_DONE;
               end
            end
            PH_SKIP2: begin
               if (b == CH_COLON) begin
                  phase_in = PH_BODY;
               end else if (b == CH_NUL) begin
                  phase_in = PH_DONE;
               end
            end
            PH_BODY: run_body = 1'b1;
            default: ;
         endcase
      end

      if (run_body) begin
         case (kind_ff)
            KIND_NONE: replay_cur = 1'b1;
            KIND_BSL: begin
               kind_in  = KIND_NONE;
               count_in = 2'd0;
               if (b == CH_NUL) begin
                  lst      = append(lst, CH_BSL);
                  phase_in = PH_DONE;
               end else begin
                  if (b == CH_N) begin
                     c = CH_LF;
                  end else if (b == CH_R) begin
                     c = CH_CR;
                  end else if (b == CH_E) begin
                     c = CH_ESC;
                  end else if (b == CH_T) begin
                     c = CH_TAB;
                  end
                  if (c == CH_ESC) begin
                     kind_in = KIND_ESC;
                  end else begin
                     lst = put_char(lst, c);
                  end
               end
            end
            KIND_EF: begin
               if (count_ff == 2'd0) begin
                  if (b == CH_94 || b == CH_98 || b == CH_9C) begin
                     held_in[0] = b;
                     count_in   = 2'd1;
                  end else begin
                     lst        = append(lst, CH_EF);
                     kind_in    = KIND_NONE;
                     replay_cur = 1'b1;
                  end
               end else if (l != CH_NUL) begin
                  kind_in  = KIND_NONE;
                  count_in = 2'd0;
                  lst      = put_color(lst, l);
               end else begin
                  lst        = append(lst, CH_EF);
                  lst        = append(lst, held_ff[0]);
                  kind_in    = KIND_NONE;
                  count_in   = 2'd0;
                  replay_cur = 1'b1;
               end
            end
            KIND_ESC: begin
               case (count_ff)
                  2'd0: begin
                     if (b == CH_LBR) begin
                        held_in[0] = b;
                        count_in   = 2'd1;
                        esc_fail   = 1'b0;
                     end
                  end
                  2'd1: begin
                     if (b == CH_D0 || b == CH_D1 || b == CH_D3 || b == CH_D4 ||
                         b == CH_D5 || b == CH_D7) begin
                        held_in[1] = b;
                        count_in   = 2'd2;
                        esc_fail   = 1'b0;
                     end
                  end
                  2'd2: begin
                     if (b == CH_M && attr_letter(held_ff[1]) != CH_NUL) begin
                        kind_in  = KIND_NONE;
                        count_in = 2'd0;
                        lst      = put_color(lst, attr_letter(held_ff[1]));
                        esc_fail = 1'b0;
                     end else if ((held_ff[1] == CH_D3 || held_ff[1] == CH_D4) &&
                                  b >= CH_D0 && b <= CH_D7) begin
                        held_in[2] = b;
                        count_in   = 2'd3;
                        esc_fail   = 1'b0;
                     end
                  end
                  default: begin
                     if (b == CH_M) begin
                        kind_in  = KIND_NONE;
                        count_in = 2'd0;
                        lst      = put_color(lst, (held_ff[1] == CH_D3) ?
                                             fg_letter(held_ff[2][2:0]) :
                                             bg_letter(held_ff[2][2:0]));
                        esc_fail = 1'b0;
                     end
                  end
               endcase
               if (esc_fail) begin
                  for (int i = 0; i < 3; i++) begin
                     if (2'(i) < count_ff) begin
                        lst = append(lst, held_ff[i]);
                     end
                  end
                  kind_in    = KIND_NONE;
                  count_in   = 2'd0;
                  replay_cur = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // current byte seen with nothing held
      if (replay_cur) begin
         if (b == CH_QUOTE || b == CH_NUL) begin
            phase_in = PH_DONE;
         end else if (b == CH_BSL) begin
            kind_in  = KIND_BSL;
            count_in = 2'd0;
         end else if (b == CH_EF) begin
            kind_in  = KIND_EF;
            count_in = 2'd0;
         end else if (b == CH_ESC) begin
            kind_in  = KIND_ESC;
            count_in = 2'd0;
         end else begin
            lst = put_char(lst, b);
         end
      end
   end

   assign req_ready           = push_ready;
   assign accept              = req_valid && req_ready;
   assign push_valid          = req_valid && (req_payload.action || lst.count != '0);
   assign push_desc.text      = lst;
   assign push_desc.value_end = req_payload.action;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         kind_ff  <= KIND_NONE;
         count_ff <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/cet_back.sv -----
// back part: plays out each descriptor one character per item
`default_nettype none

module cet_back
   import cet_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     pop_valid,
   output      logic     pop_ready,
   input  wire desc_type pop_desc,
   output      logic     rsp_valid,
   input  wire logic     rsp_ready,
   output      rsp_type  rsp_payload
);

   logic [EMIT_IDX_W-1:0] idx_ff, idx_in;
   logic                  is_bare;
   logic                  at_last;
   logic                  send;

   assign is_bare = pop_desc.text.count == '0;
   assign at_last = is_bare ||
                    ((EMIT_CNT_W'(idx_ff) + EMIT_CNT_W'(1)) == pop_desc.text.count);
   assign send    = rsp_valid && rsp_ready;

   assign rsp_valid              = pop_valid;
   assign pop_ready              = rsp_ready && at_last;
   assign rsp_payload.out_byte   = is_bare ? CH_NUL : pop_desc.text.chars[idx_ff];
   assign rsp_payload.byte_valid = !is_bare;
   assign rsp_payload.value_end  = pop_desc.value_end && at_last;
   assign rsp_payload.last       = at_last;

   always_comb begin
      idx_in = idx_ff;
      if (send) begin
         idx_in = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/color_escape_transcoder_top.sv -----
// top level of the color escape transcoder
//
// req channel: one item per raw byte of a stored value (action 0) or an
// end of value marker (action 1). rsp channel: the converted characters,
// one per item, with last on the final one caused by a request item and
// value_end on the final one of an end marker.
// the front part parses a byte in the cycle it is accepted and writes a
// descriptor of up to five characters into a queue of QUEUE_DEPTH entries;
// the back part plays a descriptor out one character per cycle while
// rsp_ready is high; each descriptor is registered in the queue before its
// first result is offered. throughput: one item per cycle while each item
// gives at most one result and rsp_ready is high; an item giving more
// results holds the back part until its last one is taken, and req_ready
// drops once the queue is full. a stalled rsp keeps its item stable; the
// front keeps accepting until the queue fills. reset empties the queue and
// returns the parser to the start of a value.
`default_nettype none

module color_escape_transcoder_top
   import cet_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_payload,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_payload
);

   logic     push_valid, push_ready;
   desc_type push_desc;
   logic     pop_valid, pop_ready;
   desc_type pop_desc;

   cet_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_desc   (push_desc)
   );

   cet_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   cet_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_desc    (pop_desc),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- src/cet_checker.sv -----
// port checks of the color escape transcoder and their bind
`default_nettype none

`include "assert_macros.svh"

module cet_checker
   import cet_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   `CET_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp valid right after reset")
   `CET_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled rsp changed")
   `CET_ASSERT(a_end_is_last, rsp_valid && rsp_payload.value_end |-> rsp_payload.last, "value end without last")
   `CET_ASSERT(a_bare_end, rsp_valid && !rsp_payload.byte_valid |-> rsp_payload.value_end && rsp_payload.out_byte == CH_NUL, "bare item not an end marker")

endmodule

bind color_escape_transcoder_top cet_checker u_checker (.*);

`default_nettype wire
